@@ hdl/ppte_pkg.sv @@
// Shared types, constants and helper functions of the trajectory evaluator.
// No dependencies.
package ppte_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int MAX_COEFFS_DEF   = 6;
    localparam int AXES_DEF         = 3;

    localparam logic [1:0] OP_LOAD_COEFF = 2'd0;
    localparam logic [1:0] OP_LOAD_DUR   = 2'd1;
    localparam logic [1:0] OP_EVAL       = 2'd2;

    localparam logic CFG_SEGMENT_COUNT = 1'b0;
    localparam logic CFG_COEFF_COUNT   = 1'b1;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clear_acc;   // start a new Horner run
        logic       horner_lo;   // stage 0: low partial product of acc by local time
        logic       horner_mul;  // stage 1: high partial product, finish acc * t
        logic       horner_add;  // stage 2: add scaled coefficient
        logic       store_res;   // write saturated accumulator to result slot
        logic [3:0] res_slot;    // k*3 + axis
        logic [2:0] deriv;       // derivative order k
        logic [2:0] power;       // coefficient power i
    } ppte_cmd_t;

    // Derivative factor i!/(i-k)! for k = 0..2.
    function automatic logic [5:0] deriv_factor(input logic [2:0] i, input logic [2:0] k);
        logic [5:0] f;
        begin
            f = 6'd1;
            if (k >= 3'd1) f = {3'd0, i};
            if (k >= 3'd2) f = 6'({3'd0, i} * ({3'd0, i} - 6'd1));
            return f;
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        begin
            if (v > 50'(ACC_MAX)) return ACC_MAX;
            if (v < 50'(ACC_MIN)) return ACC_MIN;
            return v[47:0];
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
            if (v < -48'sh0000_8000_0000) return 32'h8000_0000;
            return v[31:0];
        end
    endfunction

endpackage

@@ hdl/ppte_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module ppte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ hdl/ppte_datapath.sv @@
// Datapath: start-time registers, clamp, local time, Horner unit, result regs.
// Depends on ppte_pkg.
module ppte_datapath
    import ppte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // duration load
    input  logic                     dur_we,
    input  logic [SEG_W-1:0]         dur_seg,
    input  logic [30:0]              dur_value,
    // evaluate set-up
    input  logic                     load_time,
    input  logic [31:0]              query_time,
    input  logic [SEG_W-1:0]         seg_count,
    input  logic [SEG_W-1:0]         search_idx,
    input  logic                     set_seg,
    input  logic [SEG_W-1:0]         seg_sel,
    input  logic                     load_local,
    output logic                     time_le_start,
    // Horner
    input  ppte_cmd_t                cmd,
    input  logic [31:0]              coeff,
    output logic [31:0]              results [9]
);
    logic [31:0] start_reg [MAX_SEGMENTS+1];
    logic [32:0] time_reg;            // clamped time, non-negative
    logic [SEG_W-1:0] seg_reg;
    logic signed [33:0] t_reg;
    logic signed [47:0] acc_reg;
    logic signed [47:0] prod_reg;
    logic [31:0] res_reg [9];

    logic [32:0] sum;
    assign sum = {1'b0, start_reg[dur_seg]} + {2'b0, dur_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_SEGMENTS; i++) start_reg[i] <= '0;
        end
        else if (dur_we)
        begin
            start_reg[dur_seg + SEG_W'(1)] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
    end

    assign time_le_start = time_reg <= {1'b0, start_reg[search_idx]};

    // |acc| * |t| >> 16, truncated toward zero, on one 32x32 multiplier:
    // low half of |acc| in the read cycle, high half in the multiply cycle
    logic        neg;
    logic [47:0] ua;
    logic [31:0] ub;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [63:0] pp_lo_reg;
    logic [65:0] shifted;
    assign neg   = acc_reg[47] ^ t_reg[33];
    assign ua    = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);
    assign ub    = 32'(t_reg[33] ? -t_reg : t_reg);   // |t| < 2^32
    assign mul_a = cmd.horner_lo ? ua[31:0] : {16'd0, ua[47:32]};
    assign mul_p = mul_a * ub;

    always_ff @(posedge clk)
    begin
        if (cmd.horner_lo)
            pp_lo_reg <= mul_p;
    end
    assign shifted = 66'({mul_p, 16'd0}) + 66'(pp_lo_reg[63:16]);

    logic signed [49:0] addend;
    logic signed [38:0] cterm;
    assign cterm = $signed(coeff) * $signed({1'b0, deriv_factor(cmd.power, cmd.deriv)});
    assign addend = 50'(prod_reg) + 50'(cterm);

    always_ff @(posedge clk)
    begin
        if (load_time)
        begin
            if (query_time[31])
                time_reg <= '0;
            else if ({1'b0, query_time} > {1'b0, start_reg[seg_count]})
                time_reg <= {1'b0, start_reg[seg_count]};
            else
                time_reg <= {1'b0, query_time};
        end
        if (set_seg)
            seg_reg <= seg_sel;
        if (load_local)
            t_reg <= $signed({1'b0, time_reg}) - $signed({2'b0, start_reg[seg_reg]});
        if (cmd.clear_acc)
            acc_reg <= '0;
        else if (cmd.horner_add)
            acc_reg <= sat48(addend);
        if (cmd.horner_mul)
        begin
            if (shifted > 66'(ACC_MAX))
                prod_reg <= neg ? ACC_MIN : ACC_MAX;
            else
                prod_reg <= neg ? -$signed(shifted[47:0]) : $signed(shifted[47:0]);
        end
        if (cmd.store_res)
            res_reg[cmd.res_slot] <= sat32(acc_reg);
    end

    assign results = res_reg;
endmodule

@@ hdl/ppte_ctrl.sv @@
// Controller: handshake, coefficient RAM addressing, search and Horner sequencing.
// Depends on ppte_pkg.
module ppte_ctrl
    import ppte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int MAX_COEFFS   = MAX_COEFFS_DEF,
    parameter int AXES         = AXES_DEF,
    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1),
    localparam int ADDR_W = $clog2(MAX_SEGMENTS * AXES * MAX_COEFFS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [3:0]        seg_in,
    input  logic [1:0]        axis_in,
    input  logic [2:0]        pow_in,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        seg_used,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic              dur_we,
    output logic [SEG_W-1:0]  dur_seg,
    output logic              load_time,
    output logic [SEG_W-1:0]  seg_count,
    output logic [SEG_W-1:0]  search_idx,
    output logic              set_seg,
    output logic [SEG_W-1:0]  seg_sel,
    output logic              load_local,
    input  logic              time_le_start,
    output ppte_cmd_t         cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SEARCH = 3'd1, S_LOCAL = 3'd2,
                           S_READ = 3'd3, S_MUL = 3'd4, S_ADD = 3'd5,
                           S_STORE = 3'd6, S_OUT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [4:0] segcnt_reg;
    logic [2:0] ccnt_reg;
    logic [SEG_W-1:0] idx_reg, seg_reg;
    logic [2:0] k_reg, i_reg;
    logic [1:0] a_reg;
    logic       outv_reg;
    logic       search_step;

    logic [SEG_W-1:0] n_eff;
    logic [2:0]       nc_eff;
    always_comb
    begin
        if (segcnt_reg == 5'd0) n_eff = SEG_W'(1);
        else if (32'(segcnt_reg) > MAX_SEGMENTS) n_eff = SEG_W'(MAX_SEGMENTS);
        else n_eff = SEG_W'(segcnt_reg);
        if (ccnt_reg == 3'd0) nc_eff = 3'd1;
        else if (32'(ccnt_reg) > MAX_COEFFS) nc_eff = 3'(MAX_COEFFS);
        else nc_eff = ccnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segcnt_reg <= 5'd1;
            ccnt_reg   <= 3'd6;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SEGMENT_COUNT) segcnt_reg <= cfg_data;
            else ccnt_reg <= cfg_data[2:0];
        end
    end

    logic accept;
    assign in_ready = (state_reg == S_IDLE) && !outv_reg;
    assign accept   = in_valid && in_ready;
    assign out_valid = outv_reg;
    assign seg_used  = 4'(seg_reg);
    assign seg_count = n_eff;
    assign search_idx = idx_reg;
    assign search_step = state_reg == S_SEARCH;

    logic coeff_ok;
    assign coeff_ok = 32'(seg_in) < MAX_SEGMENTS && 32'(axis_in) < AXES
                      && 32'(pow_in) < MAX_COEFFS;

    assign ram_we   = accept && op == OP_LOAD_COEFF && coeff_ok;
    assign dur_we   = accept && op == OP_LOAD_DUR && 32'(seg_in) < MAX_SEGMENTS;
    assign dur_seg  = SEG_W'(seg_in);
    assign load_time = accept && op == OP_EVAL;
    assign set_seg  = state_reg == S_SEARCH && (time_le_start || idx_reg == n_eff);
    assign seg_sel  = time_le_start ? idx_reg - SEG_W'(1) : '0;
    assign load_local = state_reg == S_LOCAL;

    always_comb
    begin
        if (state_reg == S_IDLE)
            ram_addr = ADDR_W'((32'(seg_in) * AXES + 32'(axis_in)) * MAX_COEFFS + 32'(pow_in));
        else
            ram_addr = ADDR_W'((32'(seg_reg) * AXES + 32'(a_reg)) * MAX_COEFFS + 32'(i_reg));
    end

    always_comb
    begin
        cmd = '0;
        cmd.deriv = k_reg;
        cmd.power = i_reg;
        cmd.res_slot = 4'(32'(k_reg) * 3 + 32'(a_reg));
        cmd.clear_acc  = state_reg == S_LOCAL || state_reg == S_STORE;
        cmd.horner_lo  = state_reg == S_READ;
        cmd.horner_mul = state_reg == S_MUL;
        cmd.horner_add = state_reg == S_ADD;
        cmd.store_res  = state_reg == S_STORE;
    end

    logic last_i, last_a;
    assign last_i = i_reg == k_reg;
    assign last_a = 32'(a_reg) == AXES - 1;

    logic [2:0] next_k;
    logic [1:0] next_a;
    always_comb
    begin
        next_a = last_a ? 2'd0 : a_reg + 2'd1;
        next_k = last_a ? k_reg + 3'd1 : k_reg;
    end

    // a derivative whose order reaches nc has no terms: store the cleared acc
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (load_time) state_next = S_SEARCH;
            S_SEARCH: if (set_seg) state_next = S_LOCAL;
            S_LOCAL:  state_next = (nc_eff > 3'd0) ? S_READ : S_STORE;
            S_READ:   state_next = S_MUL;
            S_MUL:    state_next = S_ADD;
            S_ADD:    state_next = last_i ? S_STORE : S_READ;
            S_STORE:
            begin
                if (last_a && k_reg == 3'd2) state_next = S_OUT;
                else if (nc_eff > next_k) state_next = S_READ;
                else state_next = S_STORE;
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            outv_reg  <= 1'b0;
            idx_reg   <= '0;
            seg_reg   <= '0;
            k_reg     <= '0;
            a_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (outv_reg && out_ready) outv_reg <= 1'b0;
            if (state_reg == S_OUT) outv_reg <= 1'b1;
            if (load_time) idx_reg <= SEG_W'(1);
            else if (search_step) idx_reg <= idx_reg + SEG_W'(1);
            if (set_seg) seg_reg <= seg_sel;
            if (state_reg == S_LOCAL)
            begin
                k_reg <= '0;
                a_reg <= '0;
                i_reg <= nc_eff - 3'd1;
            end
            if (state_reg == S_ADD && !last_i) i_reg <= i_reg - 3'd1;
            if (state_reg == S_STORE)
            begin
                k_reg <= next_k;
                a_reg <= next_a;
                i_reg <= nc_eff - 3'd1;
            end
        end
    end
endmodule

@@ hdl/piecewise_poly_trajectory_eval.sv @@
// Top level of the piecewise polynomial trajectory evaluator.
// Depends on ppte_pkg, ppte_ram, ppte_ctrl, ppte_datapath.
//
// One word a cycle is taken for coefficient and duration loads while no
// evaluation runs or waits. After an evaluate word is accepted the block
// compares the start times 1 to n in turn, stopping at the chosen segment,
// forms the local time, then for each derivative order k and axis works
// nc - k Horner terms when nc > k (each a coefficient read with the low
// partial product, the high partial product and a scaled-coefficient add)
// and a store, and finally raises the result. The Horner terms share a
// single 32x32 multiplier and a one-read coefficient RAM. Derivatives whose
// order reaches nc are left at zero. Results wait in an output register
// until taken, no word is taken meanwhile, and input is ready again the
// cycle after the result leaves.
// Durations must be loaded in segment order.
module piecewise_poly_trajectory_eval
    import ppte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int MAX_COEFFS   = MAX_COEFFS_DEF,
    parameter int AXES         = AXES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], segment_index[5:2], axis_index[7:6], power_index[10:8],
    // coefficient_value[42:11], segment_duration[73:43], query_time[105:74]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x..z, vel_x..z, acc_x..z 32 bits each from bit 0, segment_used[291:288]
    output logic [295:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);
    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = MAX_SEGMENTS * AXES * MAX_COEFFS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic ram_we, dur_we, load_time, set_seg, load_local, le;
    logic [ADDR_W-1:0] ram_addr;
    logic [SEG_W-1:0] dur_seg, seg_count, search_idx, seg_sel;
    logic [31:0] coeff;
    logic [31:0] results [9];
    logic [3:0]  seg_used;
    ppte_cmd_t   cmd;

    assign cfg_ready = 1'b1;

    ppte_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s_tdata[42:11]), .rdata(coeff)
    );

    ppte_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_COEFFS(MAX_COEFFS), .AXES(AXES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tdata[1:0]), .seg_in(s_tdata[5:2]), .axis_in(s_tdata[7:6]),
        .pow_in(s_tdata[10:8]), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(m_tvalid), .out_ready(m_tready),
        .seg_used(seg_used), .ram_we(ram_we), .ram_addr(ram_addr), .dur_we(dur_we),
        .dur_seg(dur_seg), .load_time(load_time), .seg_count(seg_count),
        .search_idx(search_idx), .set_seg(set_seg),
        .seg_sel(seg_sel), .load_local(load_local), .time_le_start(le), .cmd(cmd)
    );

    ppte_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .dur_we(dur_we), .dur_seg(dur_seg),
        .dur_value(s_tdata[73:43]), .load_time(load_time), .query_time(s_tdata[105:74]),
        .seg_count(seg_count), .search_idx(search_idx),
        .set_seg(set_seg), .seg_sel(seg_sel), .load_local(load_local),
        .time_le_start(le), .cmd(cmd), .coeff(coeff), .results(results)
    );

    // axes beyond AXES read as zero
    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++)
                if (a < AXES) m_tdata[(k*3+a)*32 +: 32] = results[k*3+a];
        m_tdata[291:288] = seg_used;
    end
endmodule

@@ hdl/ppte_checker.sv @@
// Port-level checks of the trajectory evaluator, bound to the top level.
// Depends on piecewise_poly_trajectory_eval.
module ppte_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);
    // no new word while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready)
);
